// File: sv/c8ic_pkg.sv
// Package for the CHIP-8 instruction core: codes, defaults and ALU types.
package c8ic_pkg;

  // Default sizes handed to the top level
  localparam int MEMORY_BYTES_DEF   = 4096;
  localparam int STACK_DEPTH_DEF    = 16;
  localparam int DISPLAY_WIDTH_DEF  = 64;
  localparam int DISPLAY_HEIGHT_DEF = 32;
  localparam int BOOT_PC_DEF        = 512;

  localparam logic [11:0] FONT_BASE_RESET = 12'd80;
  localparam int          GLYPH_BYTES     = 5;

  // Item opcodes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_EXEC  = 2'd1;
  localparam logic [1:0] OP_ROW   = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // Instruction groups (top nibble)
  localparam logic [3:0] GRP_SYS   = 4'h0;
  localparam logic [3:0] GRP_JP    = 4'h1;
  localparam logic [3:0] GRP_CALL  = 4'h2;
  localparam logic [3:0] GRP_SE_K  = 4'h3;
  localparam logic [3:0] GRP_SNE_K = 4'h4;
  localparam logic [3:0] GRP_SE_V  = 4'h5;
  localparam logic [3:0] GRP_LD_K  = 4'h6;
  localparam logic [3:0] GRP_ADD_K = 4'h7;
  localparam logic [3:0] GRP_ARITH = 4'h8;
  localparam logic [3:0] GRP_SNE_V = 4'h9;
  localparam logic [3:0] GRP_LD_I  = 4'hA;
  localparam logic [3:0] GRP_JP_V0 = 4'hB;
  localparam logic [3:0] GRP_RND   = 4'hC;
  localparam logic [3:0] GRP_DRW   = 4'hD;
  localparam logic [3:0] GRP_SKEY  = 4'hE;
  localparam logic [3:0] GRP_MISC  = 4'hF;

  localparam logic [15:0] INS_CLS = 16'h00E0;
  localparam logic [15:0] INS_RET = 16'h00EE;

  localparam logic [7:0] KEY_SKP  = 8'h9E;
  localparam logic [7:0] KEY_SKNP = 8'hA1;

  localparam logic [7:0] F_LD_DT  = 8'h07;
  localparam logic [7:0] F_WAIT_K = 8'h0A;
  localparam logic [7:0] F_SET_DT = 8'h15;
  localparam logic [7:0] F_SET_ST = 8'h18;
  localparam logic [7:0] F_ADD_I  = 8'h1E;
  localparam logic [7:0] F_FONT   = 8'h29;
  localparam logic [7:0] F_BCD    = 8'h33;
  localparam logic [7:0] F_STORE  = 8'h55;
  localparam logic [7:0] F_LOAD   = 8'h65;

  // ALU ops, equal to the 8xyN low nibble
  localparam logic [3:0] ALU_MOV  = 4'h0;
  localparam logic [3:0] ALU_OR   = 4'h1;
  localparam logic [3:0] ALU_AND  = 4'h2;
  localparam logic [3:0] ALU_XOR  = 4'h3;
  localparam logic [3:0] ALU_ADD  = 4'h4;
  localparam logic [3:0] ALU_SUB  = 4'h5;
  localparam logic [3:0] ALU_SHR  = 4'h6;
  localparam logic [3:0] ALU_SUBN = 4'h7;
  localparam logic [3:0] ALU_SHL  = 4'hE;

  typedef struct packed {
    logic [3:0] op;
    logic [7:0] a;
    logic [7:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [7:0] res;
    logic       flag;
    logic       eq;
    logic       ge;
  } alu_rsp_t;

endpackage

// File: sv/c8ic_alu.sv
// Shared byte ALU: 8xyN ops, compares, and the subtract used by the mod and BCD loops.
module c8ic_alu (
  input  c8ic_pkg::alu_req_t req,
  output c8ic_pkg::alu_rsp_t rsp
);

  logic [8:0] sum;
  logic [8:0] dif;
  logic [8:0] difn;

  assign sum  = {1'b0, req.a} + {1'b0, req.b};
  assign dif  = {1'b0, req.a} - {1'b0, req.b};
  assign difn = {1'b0, req.b} - {1'b0, req.a};

  always_comb begin
    rsp.eq   = (req.a == req.b);
    rsp.ge   = ~dif[8];
    rsp.res  = req.b;
    rsp.flag = 1'b0;
    case (req.op)
      c8ic_pkg::ALU_MOV:  rsp.res = req.b;
      c8ic_pkg::ALU_OR:   rsp.res = req.a | req.b;
      c8ic_pkg::ALU_AND:  rsp.res = req.a & req.b;
      c8ic_pkg::ALU_XOR:  rsp.res = req.a ^ req.b;
      c8ic_pkg::ALU_ADD: begin
        rsp.res  = sum[7:0];
        rsp.flag = sum[8];
      end
      c8ic_pkg::ALU_SUB: begin
        rsp.res  = dif[7:0];
        rsp.flag = (req.a > req.b);
      end
      c8ic_pkg::ALU_SHR: begin
        rsp.res  = {1'b0, req.a[7:1]};
        rsp.flag = req.a[0];
      end
      c8ic_pkg::ALU_SUBN: begin
        rsp.res  = difn[7:0];
        rsp.flag = (req.b > req.a);
      end
      c8ic_pkg::ALU_SHL: begin
        rsp.res  = {req.a[6:0], 1'b0};
        rsp.flag = req.a[7];
      end
      default: begin
        rsp.res  = req.b;
        rsp.flag = 1'b0;
      end
    endcase
  end

endmodule

// File: sv/chip8_instruction_core_unit.sv
// CHIP-8 instruction core: memory, registers, display and the instruction sequencer.
//
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid/in_ready   | opcode, address, write_data, keys_down, random_byte
//  out_    | output    | out_valid/out_ready | pc, index, VF, collision, wait, sound, row, byte
//  cfg_    | input     | cfg_valid/cfg_ready | font_base
//
// Memory write and display row read go through S_DONE only, memory read through S_MRD
// and S_DONE. An instruction passes two fetch reads, two register reads, execute and
// result, plus its own loop: draw repeats a mod subtraction on x and then on y, then
// reads and writes each drawn row and finishes; BCD runs its hundreds and tens
// subtract loops and three writes; Fx55 stores V0..Vx and Fx65 reads and loads V0..Vx.
// The 8xyN ops, compares and loop subtractions run through the one ALU; the memory has
// one write and one read port. Reset is synchronous; in_ready is low while an item is
// at work and a finished result waits in the output register until out_ready.
module chip8_instruction_core_unit #(
  parameter int MEMORY_BYTES   = c8ic_pkg::MEMORY_BYTES_DEF,
  parameter int STACK_DEPTH    = c8ic_pkg::STACK_DEPTH_DEF,
  parameter int DISPLAY_WIDTH  = c8ic_pkg::DISPLAY_WIDTH_DEF,
  parameter int DISPLAY_HEIGHT = c8ic_pkg::DISPLAY_HEIGHT_DEF,
  parameter int BOOT_PC        = c8ic_pkg::BOOT_PC_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [11:0] in_address,
  input  logic [7:0]  in_write_data,
  input  logic [15:0] in_keys_down,
  input  logic [7:0]  in_random_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] out_program_counter,
  output logic [15:0] out_index_value,
  output logic [7:0]  out_flag_value,
  output logic        out_collision,
  output logic        out_waiting_for_key,
  output logic        out_sound_on,
  output logic [63:0] out_display_row,
  output logic [7:0]  out_read_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [11:0] cfg_font_base
);

  localparam int AW  = $clog2(MEMORY_BYTES);
  localparam int SPW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DHW = $clog2(DISPLAY_HEIGHT);
  localparam logic [63:0] WMASK = ~(64'hFFFF_FFFF_FFFF_FFFF >> DISPLAY_WIDTH);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_MRD  = 5'd1;
  localparam logic [4:0] S_F1   = 5'd2;
  localparam logic [4:0] S_F2   = 5'd3;
  localparam logic [4:0] S_RX   = 5'd4;
  localparam logic [4:0] S_RY   = 5'd5;
  localparam logic [4:0] S_EXEC = 5'd6;
  localparam logic [4:0] S_DMX  = 5'd7;
  localparam logic [4:0] S_DMY  = 5'd8;
  localparam logic [4:0] S_DROW = 5'd9;
  localparam logic [4:0] S_DWR  = 5'd10;
  localparam logic [4:0] S_BH   = 5'd11;
  localparam logic [4:0] S_BT   = 5'd12;
  localparam logic [4:0] S_BW0  = 5'd13;
  localparam logic [4:0] S_BW1  = 5'd14;
  localparam logic [4:0] S_BW2  = 5'd15;
  localparam logic [4:0] S_S55  = 5'd16;
  localparam logic [4:0] S_S65R = 5'd17;
  localparam logic [4:0] S_S65W = 5'd18;
  localparam logic [4:0] S_DONE = 5'd19;

  logic [4:0]  state_r, state_nxt;
  logic [11:0] pc_r;
  logic [15:0] idx_r;
  logic [SPW-1:0] sp_r;
  logic [7:0]  vreg_r [16];
  logic [11:0] stack_r [STACK_DEPTH];
  logic [63:0] disp_r [DISPLAY_HEIGHT];
  logic [7:0]  delay_r, sound_r;
  logic [11:0] font_r;

  logic [7:0]  mem_r [MEMORY_BYTES];
  logic [7:0]  mem_rdata_r;
  logic        mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]  mem_wdata;

  logic [15:0] keys_r;
  logic [7:0]  rnd_r;
  logic [7:0]  ins_hi_r, ins_lo_r;
  logic [7:0]  va_r, vb_r;
  logic [7:0]  ax_r, ay_r, acc_r;
  logic [3:0]  r_r, i_r, t_r;
  logic [1:0]  h_r;
  logic        hit_r;
  logic        res_coll_r, res_wait_r;
  logic [63:0] res_row_r;
  logic [7:0]  res_rd_r;

  logic        out_valid_r;
  logic [11:0] out_pc_r;
  logic [15:0] out_idx_r;
  logic [7:0]  out_vf_r;
  logic        out_coll_r, out_wait_r, out_snd_r;
  logic [63:0] out_row_r;
  logic [7:0]  out_rd_r;

  logic [15:0] ins;
  logic [3:0]  grp, fx, fy, fn;
  logic [7:0]  kk;
  logic [11:0] nnn, pc2;
  logic [3:0]  vrd_idx;
  logic [7:0]  vrd;
  logic [DHW-1:0] didx;
  logic [63:0] drow;
  logic [6:0]  y7;
  logic        draw_end;
  logic [63:0] smask;
  logic [SPW-1:0] spp1, spm1;
  logic [3:0]  kidx;
  logic        kany;
  logic        in_fire, out_free;
  logic [16:0] i_base;
  c8ic_pkg::alu_req_t alu_req;
  c8ic_pkg::alu_rsp_t alu_rsp;

  c8ic_alu u_alu (.req(alu_req), .rsp(alu_rsp));

  assign ins  = {ins_hi_r, ins_lo_r};
  assign grp  = ins[15:12];
  assign fx   = ins[11:8];
  assign fy   = ins[7:4];
  assign fn   = ins[3:0];
  assign kk   = ins[7:0];
  assign nnn  = ins[11:0];
  assign pc2  = pc_r + 12'd2;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;

  assign vrd  = vreg_r[vrd_idx];
  assign drow = disp_r[didx];
  assign y7   = 7'(ay_r[5:0]) + 7'(r_r);
  assign draw_end = (r_r == fn) || (y7 >= 7'(DISPLAY_HEIGHT));
  assign smask = ({mem_rdata_r, 56'd0} >> ax_r[5:0]) & WMASK;

  assign spp1 = (sp_r == SPW'(STACK_DEPTH - 1)) ? '0 : sp_r + SPW'(1);
  assign spm1 = (sp_r == '0) ? SPW'(STACK_DEPTH - 1) : sp_r - SPW'(1);

  always_comb begin
    kidx = 4'd0;
    kany = 1'b0;
    for (int k = 15; k >= 0; k--) begin
      if (keys_r[k]) begin
        kidx = 4'(k);
        kany = 1'b1;
      end
    end
  end

  // Datapath selection per state
  always_comb begin
    alu_req   = '{op: c8ic_pkg::ALU_MOV, a: va_r, b: vb_r};
    mem_we    = 1'b0;
    mem_waddr = AW'(in_address);
    mem_wdata = in_write_data;
    mem_raddr = AW'(pc_r);
    vrd_idx   = fx;
    didx      = DHW'(in_address);
    i_base    = 17'(idx_r) + 17'(i_r);
    case (state_r)
      S_IDLE: begin
        mem_we = in_fire && (in_opcode == c8ic_pkg::OP_WRITE);
        if (in_opcode == c8ic_pkg::OP_READ) mem_raddr = AW'(in_address);
      end
      S_F1: mem_raddr = AW'(17'(pc_r) + 17'd1);
      S_RX: vrd_idx = (grp == c8ic_pkg::GRP_JP_V0) ? 4'd0 : fx;
      S_RY: vrd_idx = fy;
      S_EXEC: begin
        case (grp)
          c8ic_pkg::GRP_SE_K, c8ic_pkg::GRP_SNE_K: alu_req.b = kk;
          c8ic_pkg::GRP_ADD_K: alu_req = '{op: c8ic_pkg::ALU_ADD, a: va_r, b: kk};
          c8ic_pkg::GRP_ARITH: alu_req.op = fn;
          default: ;
        endcase
      end
      S_DMX: alu_req = '{op: c8ic_pkg::ALU_SUB, a: ax_r, b: 8'(DISPLAY_WIDTH)};
      S_DMY: alu_req = '{op: c8ic_pkg::ALU_SUB, a: ay_r, b: 8'(DISPLAY_HEIGHT)};
      S_DROW: mem_raddr = AW'(17'(idx_r) + 17'(r_r));
      S_DWR: didx = y7[DHW-1:0];
      S_BH: alu_req = '{op: c8ic_pkg::ALU_SUB, a: acc_r, b: 8'd100};
      S_BT: alu_req = '{op: c8ic_pkg::ALU_SUB, a: acc_r, b: 8'd10};
      S_BW0: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(17'(idx_r));
        mem_wdata = 8'(h_r);
      end
      S_BW1: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(17'(idx_r) + 17'd1);
        mem_wdata = 8'(t_r);
      end
      S_BW2: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(17'(idx_r) + 17'd2);
        mem_wdata = acc_r;
      end
      S_S55: begin
        vrd_idx   = i_r;
        mem_we    = 1'b1;
        mem_waddr = AW'(i_base);
        mem_wdata = vrd;
      end
      S_S65R: mem_raddr = AW'(i_base);
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_opcode)
            c8ic_pkg::OP_EXEC: state_nxt = S_F1;
            c8ic_pkg::OP_READ: state_nxt = S_MRD;
            default:           state_nxt = S_DONE;
          endcase
        end
      end
      S_MRD: state_nxt = S_DONE;
      S_F1:  state_nxt = S_F2;
      S_F2:  state_nxt = S_RX;
      S_RX:  state_nxt = S_RY;
      S_RY:  state_nxt = S_EXEC;
      S_EXEC: begin
        state_nxt = S_DONE;
        if (grp == c8ic_pkg::GRP_DRW) state_nxt = S_DMX;
        else if (grp == c8ic_pkg::GRP_MISC) begin
          if (kk == c8ic_pkg::F_BCD) state_nxt = S_BH;
          else if (kk == c8ic_pkg::F_STORE) state_nxt = S_S55;
          else if (kk == c8ic_pkg::F_LOAD) state_nxt = S_S65R;
        end
      end
      S_DMX:  state_nxt = alu_rsp.ge ? S_DMX : S_DMY;
      S_DMY:  state_nxt = alu_rsp.ge ? S_DMY : S_DROW;
      S_DROW: state_nxt = draw_end ? S_DONE : S_DWR;
      S_DWR:  state_nxt = S_DROW;
      S_BH:   state_nxt = alu_rsp.ge ? S_BH : S_BT;
      S_BT:   state_nxt = alu_rsp.ge ? S_BT : S_BW0;
      S_BW0:  state_nxt = S_BW1;
      S_BW1:  state_nxt = S_BW2;
      S_BW2:  state_nxt = S_DONE;
      S_S55:  state_nxt = (i_r == fx) ? S_DONE : S_S55;
      S_S65R: state_nxt = S_S65W;
      S_S65W: state_nxt = (i_r == fx) ? S_DONE : S_S65R;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem_r[mem_waddr] <= mem_wdata;
    mem_rdata_r <= mem_r[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= 12'(BOOT_PC);
      idx_r       <= '0;
      sp_r        <= '0;
      delay_r     <= '0;
      sound_r     <= '0;
      font_r      <= c8ic_pkg::FONT_BASE_RESET;
      out_valid_r <= 1'b0;
      for (int k = 0; k < 16; k++) vreg_r[k] <= '0;
      for (int k = 0; k < STACK_DEPTH; k++) stack_r[k] <= '0;
      for (int k = 0; k < DISPLAY_HEIGHT; k++) disp_r[k] <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) font_r <= cfg_font_base;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            keys_r     <= in_keys_down;
            rnd_r      <= in_random_byte;
            res_coll_r <= 1'b0;
            res_wait_r <= 1'b0;
            res_rd_r   <= '0;
            res_row_r  <= '0;
            if (in_opcode == c8ic_pkg::OP_ROW && in_address < 12'(DISPLAY_HEIGHT))
              res_row_r <= drow;
          end
        end
        S_MRD: res_rd_r <= mem_rdata_r;
        S_F1:  ins_hi_r <= mem_rdata_r;
        S_F2:  ins_lo_r <= mem_rdata_r;
        S_RX:  va_r <= vrd;
        S_RY:  vb_r <= vrd;
        S_EXEC: begin
          pc_r <= pc2;
          ax_r <= va_r;
          ay_r <= vb_r;
          r_r  <= '0;
          i_r  <= '0;
          hit_r <= 1'b0;
          case (grp)
            c8ic_pkg::GRP_SYS: begin
              if (ins == c8ic_pkg::INS_CLS) begin
                for (int k = 0; k < DISPLAY_HEIGHT; k++) disp_r[k] <= '0;
              end else if (ins == c8ic_pkg::INS_RET) begin
                sp_r <= spm1;
                pc_r <= stack_r[spm1];
              end
            end
            c8ic_pkg::GRP_JP: pc_r <= nnn;
            c8ic_pkg::GRP_CALL: begin
              stack_r[sp_r] <= pc2;
              sp_r <= spp1;
              pc_r <= nnn;
            end
            c8ic_pkg::GRP_SE_K, c8ic_pkg::GRP_SE_V:
              if (alu_rsp.eq) pc_r <= pc_r + 12'd4;
            c8ic_pkg::GRP_SNE_K, c8ic_pkg::GRP_SNE_V:
              if (!alu_rsp.eq) pc_r <= pc_r + 12'd4;
            c8ic_pkg::GRP_LD_K:  vreg_r[fx] <= kk;
            c8ic_pkg::GRP_ADD_K: vreg_r[fx] <= alu_rsp.res;
            c8ic_pkg::GRP_ARITH: begin
              if (fn <= c8ic_pkg::ALU_SUBN || fn == c8ic_pkg::ALU_SHL) begin
                // flag first so that x = F keeps the result value
                if (fn >= c8ic_pkg::ALU_ADD) vreg_r[15] <= 8'(alu_rsp.flag);
                vreg_r[fx] <= alu_rsp.res;
              end
            end
            c8ic_pkg::GRP_LD_I:  idx_r <= 16'(nnn);
            c8ic_pkg::GRP_JP_V0: pc_r <= 12'(va_r) + nnn;
            c8ic_pkg::GRP_RND:   vreg_r[fx] <= rnd_r & kk;
            c8ic_pkg::GRP_SKEY: begin
              if ((kk == c8ic_pkg::KEY_SKP && keys_r[va_r[3:0]]) ||
                  (kk == c8ic_pkg::KEY_SKNP && !keys_r[va_r[3:0]]))
                pc_r <= pc_r + 12'd4;
            end
            c8ic_pkg::GRP_MISC: begin
              case (kk)
                c8ic_pkg::F_LD_DT: vreg_r[fx] <= delay_r;
                c8ic_pkg::F_WAIT_K: begin
                  if (kany) vreg_r[fx] <= 8'(kidx);
                  else begin
                    pc_r       <= pc_r;
                    res_wait_r <= 1'b1;
                  end
                end
                c8ic_pkg::F_SET_DT: delay_r <= va_r;
                c8ic_pkg::F_SET_ST: sound_r <= va_r;
                c8ic_pkg::F_ADD_I:  idx_r <= idx_r + 16'(va_r);
                c8ic_pkg::F_FONT:
                  idx_r <= 16'(font_r) + 16'(va_r) * 16'(c8ic_pkg::GLYPH_BYTES);
                c8ic_pkg::F_BCD: begin
                  acc_r <= va_r;
                  h_r   <= '0;
                  t_r   <= '0;
                end
                default: ;
              endcase
            end
            default: ;
          endcase
        end
        S_DMX: if (alu_rsp.ge) ax_r <= alu_rsp.res;
        S_DMY: if (alu_rsp.ge) ay_r <= alu_rsp.res;
        S_DROW: begin
          if (draw_end) begin
            vreg_r[15] <= 8'(hit_r);
            res_coll_r <= hit_r;
          end
        end
        S_DWR: begin
          disp_r[didx] <= drow ^ smask;
          if (|(drow & smask)) hit_r <= 1'b1;
          r_r <= r_r + 4'd1;
        end
        S_BH: begin
          if (alu_rsp.ge) begin
            acc_r <= alu_rsp.res;
            h_r   <= h_r + 2'd1;
          end
        end
        S_BT: begin
          if (alu_rsp.ge) begin
            acc_r <= alu_rsp.res;
            t_r   <= t_r + 4'd1;
          end
        end
        S_S55: i_r <= i_r + 4'd1;
        S_S65W: begin
          vreg_r[i_r] <= mem_rdata_r;
          i_r <= i_r + 4'd1;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_pc_r    <= pc_r;
            out_idx_r   <= idx_r;
            out_vf_r    <= vreg_r[15];
            out_coll_r  <= res_coll_r;
            out_wait_r  <= res_wait_r;
            out_snd_r   <= (sound_r != 8'd0);
            out_row_r   <= res_row_r;
            out_rd_r    <= res_rd_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_program_counter = out_pc_r;
  assign out_index_value     = out_idx_r;
  assign out_flag_value      = out_vf_r;
  assign out_collision       = out_coll_r;
  assign out_waiting_for_key = out_wait_r;
  assign out_sound_on        = out_snd_r;
  assign out_display_row     = out_row_r;
  assign out_read_data       = out_rd_r;

endmodule
